// ----- design/segx_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, payload types and helpers for the segment intersection core
// no dependencies

package segx_pkg;

    localparam int CB  = 16;          // coordinate bits
    localparam int DW  = CB + 1;      // coordinate difference
    localparam int PW  = 2 * DW;      // difference product
    localparam int TW  = PW + 1;      // determinant and numerator term
    localparam int NW  = CB + TW + 2; // full numerator
    localparam int QW  = CB + 1;      // quotient magnitude bits
    localparam int QD  = 4;           // queue depth
    localparam int QAW = $clog2(QD);

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        logic            miss;
        logic signed [TW-1:0] den;
        logic signed [TW-1:0] f;
        diff_t           mx;
        diff_t           my;
        coord_t          x0;
        coord_t          y0;
        coord_t          xlo;
        coord_t          xhi;
        coord_t          ylo;
        coord_t          yhi;
    } job_t;

    function automatic coord_t smin(input coord_t p, input coord_t q);
        return (p < q) ? p : q;
    endfunction

    function automatic coord_t smax(input coord_t p, input coord_t q);
        return (p > q) ? p : q;
    endfunction

endpackage

// ----- design/segx_in_if.sv -----
`timescale 1ns / 1ps
// request channel carrying two segments
// depends on segx_pkg

interface segx_in_if;
    logic valid;
    logic ready;
    segx_pkg::coord_t a_x;
    segx_pkg::coord_t a_y;
    segx_pkg::coord_t b_x;
    segx_pkg::coord_t b_y;
    segx_pkg::coord_t c_x;
    segx_pkg::coord_t c_y;
    segx_pkg::coord_t d_x;
    segx_pkg::coord_t d_y;

    modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
    modport sink (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

// ----- design/segx_out_if.sv -----
`timescale 1ns / 1ps
// result channel carrying hit flag and intersection point
// depends on segx_pkg

interface segx_out_if;
    logic valid;
    logic ready;
    logic hit;
    segx_pkg::coord_t cross_x;
    segx_pkg::coord_t cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

// ----- design/segx_core.sv -----
`timescale 1ns / 1ps
// throughput: one request per cycle while the job queue has room for the front end;
// the 17-stage quotient pipeline sets the depth
// a 4-entry job queue with a registered head lets the front keep taking requests
// while the result side stalls
// reset: rst_n asynchronous active low clears all valid flags and the queue pointers
// depends on segx_pkg, segx_in_if, segx_out_if, segx_front, segx_queue, segx_back

module segment_intersection_2d_core (
    input  logic        clk,
    input  logic        rst_n,
    segx_in_if.sink     segs,
    segx_out_if.source  result
);

    logic           fj_valid, fj_ready, bj_valid, bj_ready;
    segx_pkg::job_t fj, bj;

    segx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .segs      (segs),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj)
    );

    segx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (bj)
    );

    segx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .result    (result)
    );

endmodule

// ----- design/segx_front.sv -----
`timescale 1ns / 1ps
// front end: takes a request, forms differences, determinant and case, emits a job
// depends on segx_pkg and segx_in_if

module segx_front (
    input  logic            clk,
    input  logic            rst_n,
    segx_in_if.sink         segs,
    output logic            job_valid,
    input  logic            job_ready,
    output segx_pkg::job_t  job
);

    localparam int DW = segx_pkg::DW;
    localparam int PW = segx_pkg::PW;
    localparam int TW = segx_pkg::TW;

    typedef struct packed {
        logic vab;
        logic vcd;
        logic ptm;
        segx_pkg::coord_t ax;
        segx_pkg::coord_t ay;
        segx_pkg::coord_t cx;
        segx_pkg::coord_t cy;
        segx_pkg::diff_t ux;
        segx_pkg::diff_t uy;
        segx_pkg::diff_t vx;
        segx_pkg::diff_t vy;
        segx_pkg::diff_t wx;
        segx_pkg::diff_t wy;
        segx_pkg::coord_t xlo;
        segx_pkg::coord_t xhi;
        segx_pkg::coord_t ylo;
        segx_pkg::coord_t yhi;
    } dif_t;

    typedef struct packed {
        dif_t dv;
        logic signed [PW-1:0] pa;
        logic signed [PW-1:0] pb;
        logic signed [PW-1:0] pc;
        logic signed [PW-1:0] pd;
    } prd_t;

    logic en;
    logic v1_reg, v2_reg, v3_reg;
    dif_t s1_reg, s1_next;
    prd_t s2_reg, s2_next;
    segx_pkg::job_t s3_reg, s3_next;

    assign en         = !v3_reg || job_ready;
    assign segs.ready = en;
    assign job_valid  = v3_reg;
    assign job        = s3_reg;

    always_comb
    begin
        s1_next.ax  = segs.a_x;
        s1_next.ay  = segs.a_y;
        s1_next.cx  = segs.c_x;
        s1_next.cy  = segs.c_y;
        s1_next.ux  = DW'(segs.b_x) - DW'(segs.a_x);
        s1_next.uy  = DW'(segs.b_y) - DW'(segs.a_y);
        s1_next.vx  = DW'(segs.d_x) - DW'(segs.c_x);
        s1_next.vy  = DW'(segs.d_y) - DW'(segs.c_y);
        s1_next.wx  = DW'(segs.c_x) - DW'(segs.a_x);
        s1_next.wy  = DW'(segs.c_y) - DW'(segs.a_y);
        s1_next.vab = (segs.a_x == segs.b_x);
        s1_next.vcd = (segs.c_x == segs.d_x);
        s1_next.ptm = ((segs.a_x == segs.c_x) && (segs.a_y == segs.c_y)) ||
                      ((segs.a_x == segs.d_x) && (segs.a_y == segs.d_y));
        s1_next.xlo = segx_pkg::smax(segx_pkg::smin(segs.a_x, segs.b_x),
                                     segx_pkg::smin(segs.c_x, segs.d_x));
        s1_next.xhi = segx_pkg::smin(segx_pkg::smax(segs.a_x, segs.b_x),
                                     segx_pkg::smax(segs.c_x, segs.d_x));
        s1_next.ylo = segx_pkg::smax(segx_pkg::smin(segs.a_y, segs.b_y),
                                     segx_pkg::smin(segs.c_y, segs.d_y));
        s1_next.yhi = segx_pkg::smin(segx_pkg::smax(segs.a_y, segs.b_y),
                                     segx_pkg::smax(segs.c_y, segs.d_y));
    end

    always_comb
    begin
        s2_next.dv = s1_reg;
        s2_next.pa = PW'(s1_reg.ux) * PW'(s1_reg.vy);
        s2_next.pb = PW'(s1_reg.uy) * PW'(s1_reg.vx);
        s2_next.pc = PW'(s1_reg.wx) * PW'(s1_reg.vy);
        s2_next.pd = PW'(s1_reg.wy) * PW'(s1_reg.vx);
    end

    always_comb
    begin
        logic signed [TW-1:0] d;
        logic signed [TW-1:0] t;
        d = TW'(s2_reg.pa) - TW'(s2_reg.pb);
        t = TW'(s2_reg.pc) - TW'(s2_reg.pd);
        s3_next.miss = 1'b0;
        s3_next.den  = TW'(1);
        s3_next.f    = '0;
        s3_next.mx   = '0;
        s3_next.my   = '0;
        s3_next.x0   = s2_reg.dv.ax;
        s3_next.y0   = s2_reg.dv.ay;
        s3_next.xlo  = s2_reg.dv.xlo;
        s3_next.xhi  = s2_reg.dv.xhi;
        s3_next.ylo  = s2_reg.dv.ylo;
        s3_next.yhi  = s2_reg.dv.yhi;
        if (s2_reg.dv.vab && s2_reg.dv.vcd)
        begin
            s3_next.miss = 1'b1;
        end
        else if (s2_reg.dv.vab)
        begin
            // vertical first segment
            s3_next.y0 = s2_reg.dv.cy;
            s3_next.f  = TW'(-s2_reg.dv.wx);
            if (s2_reg.dv.vx > 0)
            begin
                s3_next.den = TW'(s2_reg.dv.vx);
                s3_next.my  = s2_reg.dv.vy;
            end
            else
            begin
                s3_next.den = TW'(-s2_reg.dv.vx);
                s3_next.my  = -s2_reg.dv.vy;
            end
        end
        else if (s2_reg.dv.vcd)
        begin
            // vertical second segment
            s3_next.x0 = s2_reg.dv.cx;
            s3_next.f  = TW'(s2_reg.dv.wx);
            if (s2_reg.dv.ux > 0)
            begin
                s3_next.den = TW'(s2_reg.dv.ux);
                s3_next.my  = s2_reg.dv.uy;
            end
            else
            begin
                s3_next.den = TW'(-s2_reg.dv.ux);
                s3_next.my  = -s2_reg.dv.uy;
            end
        end
        else if (s2_reg.dv.ptm)
        begin
            s3_next.den = TW'(1);
        end
        else if (d == 0)
        begin
            s3_next.miss = 1'b1;
        end
        else
        begin
            s3_next.mx  = s2_reg.dv.ux;
            s3_next.my  = s2_reg.dv.uy;
            s3_next.den = (d < 0) ? -d : d;
            s3_next.f   = (d < 0) ? -t : t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= segs.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

endmodule

// ----- design/segx_queue.sv -----
`timescale 1ns / 1ps
// short job queue between front and back ends, with a registered head
// depends on segx_pkg

module segx_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  segx_pkg::job_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output segx_pkg::job_t  rd_data
);

    localparam int QAW = segx_pkg::QAW;

    segx_pkg::job_t mem [segx_pkg::QD];
    segx_pkg::job_t head_reg;
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           hv_reg;
    logic wr, take, pull, pass, put;

    assign wr_ready = (cnt_reg != (QAW+1)'(segx_pkg::QD));
    assign rd_valid = hv_reg;
    assign rd_data  = head_reg;
    assign wr       = wr_valid && wr_ready;
    // head register free or being drained
    assign take     = !hv_reg || rd_ready;
    assign pull     = take && (cnt_reg != '0);
    // empty queue and head free or being drained: new job goes straight to the head
    assign pass     = take && (cnt_reg == '0) && wr;
    assign put      = wr && !pass;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            hv_reg  <= 1'b0;
        end
        else
        begin
            if (put)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pull)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (put && !pull)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pull && !put)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (pull || pass)
            begin
                hv_reg <= 1'b1;
            end
            else if (rd_ready)
            begin
                hv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (pull)
        begin
            head_reg <= mem[rp_reg];
        end
        else if (pass)
        begin
            head_reg <= wr_data;
        end
    end

endmodule

// ----- design/segx_back.sv -----
`timescale 1ns / 1ps
// back end: numerators, pipelined restoring divide, box test and result register
// depends on segx_pkg and segx_out_if

module segx_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  segx_pkg::job_t  job,
    segx_out_if.source      result
);

    localparam int CB = segx_pkg::CB;
    localparam int TW = segx_pkg::TW;
    localparam int NW = segx_pkg::NW;
    localparam int QW = segx_pkg::QW;
    localparam int RW = QW + 2;

    typedef struct packed {
        logic miss;
        logic [TW-1:0] den;
        logic signed [NW-1:0] px;
        logic signed [NW-1:0] qx;
        logic signed [NW-1:0] py;
        logic signed [NW-1:0] qy;
        segx_pkg::coord_t xlo;
        segx_pkg::coord_t xhi;
        segx_pkg::coord_t ylo;
        segx_pkg::coord_t yhi;
    } mul_t;

    typedef struct packed {
        logic miss;
        logic [TW-1:0] den;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        segx_pkg::coord_t xlo;
        segx_pkg::coord_t xhi;
        segx_pkg::coord_t ylo;
        segx_pkg::coord_t yhi;
    } sum_t;

    typedef struct packed {
        logic miss;
        logic [TW-1:0] den;
        logic negx;
        logic negy;
        logic [NW-1:0] rx;
        logic [NW-1:0] ry;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        segx_pkg::coord_t xlo;
        segx_pkg::coord_t xhi;
        segx_pkg::coord_t ylo;
        segx_pkg::coord_t yhi;
    } div_t;

    logic en;
    logic v1_reg, v2_reg, vo_reg;
    logic [QW:0] vd_reg;
    mul_t s1_reg, s1_next;
    sum_t s2_reg, s2_next;
    div_t dv_reg [QW+1];
    div_t dv_next [QW+1];
    logic hit_reg, hit_next;
    segx_pkg::coord_t cx_reg, cx_next, cy_reg, cy_next;

    assign en           = !vo_reg || result.ready;
    assign job_ready    = en;
    assign result.valid = vo_reg;
    assign result.hit   = hit_reg;
    assign result.cross_x = cx_reg;
    assign result.cross_y = cy_reg;

    always_comb
    begin
        s1_next.miss = job.miss;
        s1_next.den  = job.den;
        s1_next.px   = NW'(job.x0) * NW'(job.den);
        s1_next.qx   = NW'(job.mx) * NW'(job.f);
        s1_next.py   = NW'(job.y0) * NW'(job.den);
        s1_next.qy   = NW'(job.my) * NW'(job.f);
        s1_next.xlo  = job.xlo;
        s1_next.xhi  = job.xhi;
        s1_next.ylo  = job.ylo;
        s1_next.yhi  = job.yhi;
    end

    always_comb
    begin
        s2_next.miss = s1_reg.miss;
        s2_next.den  = s1_reg.den;
        s2_next.nx   = s1_reg.px + s1_reg.qx;
        s2_next.ny   = s1_reg.py + s1_reg.qy;
        s2_next.xlo  = s1_reg.xlo;
        s2_next.xhi  = s1_reg.xhi;
        s2_next.ylo  = s1_reg.ylo;
        s2_next.yhi  = s1_reg.yhi;
    end

    // magnitudes and quotient range check, then one quotient bit per stage
    always_comb
    begin
        logic [NW-1:0] lim;
        logic [NW-1:0] dsh;
        dv_next[0].den  = s2_reg.den;
        dv_next[0].negx = s2_reg.nx < 0;
        dv_next[0].negy = s2_reg.ny < 0;
        dv_next[0].rx   = (s2_reg.nx < 0) ? NW'(-s2_reg.nx) : NW'(s2_reg.nx);
        dv_next[0].ry   = (s2_reg.ny < 0) ? NW'(-s2_reg.ny) : NW'(s2_reg.ny);
        dv_next[0].qx   = '0;
        dv_next[0].qy   = '0;
        dv_next[0].xlo  = s2_reg.xlo;
        dv_next[0].xhi  = s2_reg.xhi;
        dv_next[0].ylo  = s2_reg.ylo;
        dv_next[0].yhi  = s2_reg.yhi;
        lim = NW'(s2_reg.den) << QW;
        dv_next[0].miss = s2_reg.miss || (dv_next[0].rx >= lim) || (dv_next[0].ry >= lim);
        for (int k = 1; k <= QW; k++)
        begin
            dv_next[k] = dv_reg[k-1];
            dsh = NW'(dv_reg[k-1].den) << (QW - k);
            if (dv_reg[k-1].rx >= dsh)
            begin
                dv_next[k].rx         = dv_reg[k-1].rx - dsh;
                dv_next[k].qx[QW - k] = 1'b1;
            end
            if (dv_reg[k-1].ry >= dsh)
            begin
                dv_next[k].ry         = dv_reg[k-1].ry - dsh;
                dv_next[k].qy[QW - k] = 1'b1;
            end
        end
    end

    // truncate, then test against the overlap of both boxes
    always_comb
    begin
        logic signed [RW-1:0] tx, ty, lx, hx, ly, hy;
        logic inx, iny, okx, oky;
        tx  = $signed(RW'(dv_reg[QW].qx));
        ty  = $signed(RW'(dv_reg[QW].qy));
        if (dv_reg[QW].negx)
        begin
            tx = -tx;
        end
        if (dv_reg[QW].negy)
        begin
            ty = -ty;
        end
        inx = (dv_reg[QW].rx != '0);
        iny = (dv_reg[QW].ry != '0);
        lx  = tx - RW'(inx && dv_reg[QW].negx);
        hx  = tx + RW'(inx && !dv_reg[QW].negx);
        ly  = ty - RW'(iny && dv_reg[QW].negy);
        hy  = ty + RW'(iny && !dv_reg[QW].negy);
        okx = (lx >= RW'(dv_reg[QW].xlo)) && (hx <= RW'(dv_reg[QW].xhi));
        oky = (ly >= RW'(dv_reg[QW].ylo)) && (hy <= RW'(dv_reg[QW].yhi));
        hit_next = !dv_reg[QW].miss && okx && oky;
        cx_next  = hit_next ? tx[CB-1:0] : '1;
        cy_next  = hit_next ? ty[CB-1:0] : '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vd_reg <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= job_valid;
            v2_reg <= v1_reg;
            vd_reg <= {vd_reg[QW-1:0], v2_reg};
            vo_reg <= vd_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            for (int k = 0; k <= QW; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            hit_reg <= hit_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

endmodule
